// ===== design/cmnp_pkg.sv =====
package cmnp_pkg;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] KIND_MOVE = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [2:0] PC_PAWN   = 3'd0;
   localparam logic [2:0] PC_KNIGHT = 3'd1;
   localparam logic [2:0] PC_BISHOP = 3'd2;
   localparam logic [2:0] PC_ROOK   = 3'd3;
   localparam logic [2:0] PC_QUEEN  = 3'd4;
   localparam logic [2:0] PC_KING   = 3'd5;

   localparam logic signed [3:0] SQ_NONE = -4'sd1;

   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_O     = 8'h4f;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_8     = 8'h38;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_N     = 8'h4e;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_Q     = 8'h51;
   localparam logic [7:0] CH_K     = 8'h4b;

   typedef enum logic [13:0] {
      PH_START    = 14'b00000000000001,
      PH_C1       = 14'b00000000000010,
      PH_C2       = 14'b00000000000100,
      PH_C3       = 14'b00000000001000,
      PH_C4       = 14'b00000000010000,
      PH_PAWN_F   = 14'b00000000100000,
      PH_PROMO    = 14'b00000001000000,
      PH_PROMO_EQ = 14'b00000010000000,
      PH_PC1      = 14'b00000100000000,
      PH_PC_F     = 14'b00001000000000,
      PH_PC_FR    = 14'b00010000000000,
      PH_PC_R     = 14'b00100000000000,
      PH_DST_F    = 14'b01000000000000,
      PH_DST_R    = 14'b10000000000000
   } phase_type;

   typedef struct packed {
      logic [2:0]        piece;
      logic signed [3:0] first_file;
      logic signed [3:0] first_rank;
      logic signed [3:0] dest_file;
      logic signed [3:0] dest_rank;
      logic              capture;
   } hold_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        piece;
      logic signed [3:0] origin_file;
      logic signed [3:0] origin_rank;
      logic signed [3:0] target_file;
      logic signed [3:0] target_rank;
      logic              captures;
      logic              castle_short;
      logic              castle_long;
      logic [2:0]        promoted_to;
      logic [7:0]        bad_byte;
      logic              last;
   } res_type;

   localparam hold_type HOLD_CLEAR = '{
      piece: PC_PAWN, first_file: SQ_NONE, first_rank: SQ_NONE,
      dest_file: SQ_NONE, dest_rank: SQ_NONE, capture: 1'b0};

   function automatic logic is_file(input logic [7:0] c);
      return (c >= CH_A) && (c <= CH_H);
   endfunction

   function automatic logic is_rank(input logic [7:0] c);
      return (c >= CH_1) && (c <= CH_8);
   endfunction

   function automatic logic signed [3:0] file_val(input logic [7:0] c);
      logic [7:0] d;
      d = c - CH_A;
      return signed'({1'b0, d[2:0]});
   endfunction

   function automatic logic signed [3:0] rank_val(input logic [7:0] c);
      logic [7:0] d;
      d = c - CH_1;
      return signed'({1'b0, d[2:0]});
   endfunction

   function automatic logic [2:0] letter_piece(input logic [7:0] c);
      logic [2:0] p;
      p = PC_PAWN;
      unique case (c)
         CH_N:    p = PC_KNIGHT;
         CH_B:    p = PC_BISHOP;
         CH_R:    p = PC_ROOK;
         CH_Q:    p = PC_QUEEN;
         CH_K:    p = PC_KING;
         default: p = PC_PAWN;
      endcase
      return p;
   endfunction

   function automatic res_type mk_blank(input logic [1:0] kind, input logic [7:0] bad);
      res_type r;
      r.kind         = kind;
      r.piece        = PC_PAWN;
      r.origin_file  = SQ_NONE;
      r.origin_rank  = SQ_NONE;
      r.target_file  = SQ_NONE;
      r.target_rank  = SQ_NONE;
      r.captures     = 1'b0;
      r.castle_short = 1'b0;
      r.castle_long  = 1'b0;
      r.promoted_to  = PC_PAWN;
      r.bad_byte     = bad;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic res_type mk_castle(input logic is_long);
      res_type r;
      r              = mk_blank(KIND_MOVE, 8'd0);
      r.piece        = PC_KING;
      r.castle_short = !is_long;
      r.castle_long  = is_long;
      return r;
   endfunction

   function automatic res_type mk_move(input hold_type h, input logic [2:0] promo);
      res_type r;
      r             = mk_blank(KIND_MOVE, 8'd0);
      r.piece       = h.piece;
      r.origin_file = h.first_file;
      r.origin_rank = h.first_rank;
      r.target_file = h.dest_file;
      r.target_rank = h.dest_rank;
      r.captures    = h.capture;
      r.promoted_to = promo;
      return r;
   endfunction

endpackage

// ===== design/cmnp_req_if.sv =====
interface cmnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

// ===== design/cmnp_rsp_if.sv =====
interface cmnp_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [2:0]        piece;
   logic signed [3:0] origin_file;
   logic signed [3:0] origin_rank;
   logic signed [3:0] target_file;
   logic signed [3:0] target_rank;
   logic              captures;
   logic              castle_short;
   logic              castle_long;
   logic [2:0]        promoted_to;
   logic [7:0]        bad_byte;
   logic              last;

   modport source (output valid, output kind, output piece, output origin_file,
                   output origin_rank, output target_file, output target_rank,
                   output captures, output castle_short, output castle_long,
                   output promoted_to, output bad_byte, output last, input ready);
   modport sink (input valid, input kind, input piece, input origin_file,
                 input origin_rank, input target_file, input target_rank,
                 input captures, input castle_short, input castle_long,
                 input promoted_to, input bad_byte, input last, output ready);
endinterface

// ===== design/chess_move_notation_parser.sv =====
// Results of an accepted request are registered into the result queue and shown on rsp_chan in order.
// Throughput: one request per cycle while the four-entry result queue holds two or fewer
// results; a request that yields two results pushes both into the queue together.
// Reset (synchronous): parse state returns to start of move, held move fields to their
// defaults, and the result queue empties.
module chess_move_notation_parser (
   input  logic      clock,
   input  logic      reset,
   cmnp_req_if.sink  req_chan,
   cmnp_rsp_if.source rsp_chan
);

   typedef struct packed {
      cmnp_pkg::phase_type phase;
      logic                emit;
      cmnp_pkg::res_type   res;
      cmnp_pkg::hold_type  held;
   } start_type;

   cmnp_pkg::phase_type ph_ff, ph_in;
   cmnp_pkg::hold_type  held_ff, held_in;
   cmnp_pkg::res_type   r0, r1;
   logic [1:0]          n_res, push_n;
   logic                acc, pop;
   logic [7:0]          c;
   start_type           st;

   cmnp_pkg::res_type                 mem_ff [cmnp_pkg::Q_DEPTH];
   logic [cmnp_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [cmnp_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   cmnp_pkg::res_type                 head;

   function automatic start_type start_byte(input logic [7:0] ch,
                                            input cmnp_pkg::hold_type h);
      start_type s;
      s.phase = cmnp_pkg::PH_START;
      s.emit  = 1'b0;
      s.res   = cmnp_pkg::mk_blank(cmnp_pkg::KIND_EOL, 8'd0);
      s.held  = h;
      if (ch == cmnp_pkg::CH_SPACE) begin
         s.emit = 1'b0;
      end else if (ch == cmnp_pkg::CH_LF || ch == cmnp_pkg::CH_CR) begin
         s.emit = 1'b1;
      end else begin
         s.held = cmnp_pkg::HOLD_CLEAR;
         if (ch == cmnp_pkg::CH_O) begin
            s.held.piece = cmnp_pkg::PC_KING;
            s.phase      = cmnp_pkg::PH_C1;
         end else if (cmnp_pkg::is_file(ch)) begin
            s.held.first_file = cmnp_pkg::file_val(ch);
            s.phase           = cmnp_pkg::PH_PAWN_F;
         end else if (cmnp_pkg::letter_piece(ch) != cmnp_pkg::PC_PAWN) begin
            s.held.piece = cmnp_pkg::letter_piece(ch);
            s.phase      = cmnp_pkg::PH_PC1;
         end else begin
            s.emit = 1'b1;
            s.res  = cmnp_pkg::mk_blank(cmnp_pkg::KIND_ERR, ch);
         end
      end
      return s;
   endfunction

   assign c   = req_chan.char_byte;
   assign acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (count_ff <= cmnp_pkg::Q_CNT_W'(cmnp_pkg::Q_DEPTH - 2));

   always_comb begin
      ph_in   = ph_ff;
      held_in = held_ff;
      n_res   = 2'd0;
      r0      = cmnp_pkg::mk_blank(cmnp_pkg::KIND_ERR, c);
      r1      = cmnp_pkg::mk_blank(cmnp_pkg::KIND_ERR, c);
      st      = start_byte(c, held_ff);
      unique case (ph_ff)
         cmnp_pkg::PH_C1: begin
            if (c == cmnp_pkg::CH_DASH) ph_in = cmnp_pkg::PH_C2;
            else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_C2: begin
            if (c == cmnp_pkg::CH_O) ph_in = cmnp_pkg::PH_C3;
            else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_C3: begin
            if (c == cmnp_pkg::CH_DASH) ph_in = cmnp_pkg::PH_C4;
            else begin
               r0      = cmnp_pkg::mk_castle(1'b0);
               r1      = st.res;
               ph_in   = st.phase;
               held_in = st.held;
               n_res   = st.emit ? 2'd2 : 2'd1;
            end
         end
         cmnp_pkg::PH_C4: begin
            ph_in = cmnp_pkg::PH_START;
            n_res = 2'd1;
            if (c == cmnp_pkg::CH_O) r0 = cmnp_pkg::mk_castle(1'b1);
         end
         cmnp_pkg::PH_PAWN_F: begin
            if (c == cmnp_pkg::CH_X) begin
               held_in.capture = 1'b1;
               ph_in           = cmnp_pkg::PH_DST_F;
            end else if (cmnp_pkg::is_rank(c)) begin
               held_in.dest_file  = held_ff.first_file;
               held_in.first_file = cmnp_pkg::SQ_NONE;
               held_in.dest_rank  = cmnp_pkg::rank_val(c);
               ph_in              = cmnp_pkg::PH_PROMO;
            end else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_PROMO: begin
            if (c == cmnp_pkg::CH_EQ) ph_in = cmnp_pkg::PH_PROMO_EQ;
            else begin
               r0      = cmnp_pkg::mk_move(held_ff, cmnp_pkg::PC_PAWN);
               r1      = st.res;
               ph_in   = st.phase;
               held_in = st.held;
               n_res   = st.emit ? 2'd2 : 2'd1;
            end
         end
         cmnp_pkg::PH_PROMO_EQ: begin
            ph_in = cmnp_pkg::PH_START;
            n_res = 2'd1;
            if (c == cmnp_pkg::CH_Q || c == cmnp_pkg::CH_R ||
                c == cmnp_pkg::CH_B || c == cmnp_pkg::CH_N)
               r0 = cmnp_pkg::mk_move(held_ff, cmnp_pkg::letter_piece(c));
         end
         cmnp_pkg::PH_PC1: begin
            if (cmnp_pkg::is_file(c)) begin
               held_in.first_file = cmnp_pkg::file_val(c);
               ph_in              = cmnp_pkg::PH_PC_F;
            end else if (cmnp_pkg::is_rank(c)) begin
               held_in.first_rank = cmnp_pkg::rank_val(c);
               ph_in              = cmnp_pkg::PH_PC_R;
            end else if (c == cmnp_pkg::CH_X) begin
               held_in.capture = 1'b1;
               ph_in           = cmnp_pkg::PH_DST_F;
            end else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_PC_F: begin
            if (cmnp_pkg::is_rank(c)) begin
               held_in.first_rank = cmnp_pkg::rank_val(c);
               ph_in              = cmnp_pkg::PH_PC_FR;
            end else if (c == cmnp_pkg::CH_X) begin
               held_in.capture = 1'b1;
               ph_in           = cmnp_pkg::PH_DST_F;
            end else if (cmnp_pkg::is_file(c)) begin
               held_in.dest_file = cmnp_pkg::file_val(c);
               ph_in             = cmnp_pkg::PH_DST_R;
            end else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_PC_FR: begin
            if (c == cmnp_pkg::CH_X) begin
               held_in.capture = 1'b1;
               ph_in           = cmnp_pkg::PH_DST_F;
            end else if (cmnp_pkg::is_file(c)) begin
               held_in.dest_file = cmnp_pkg::file_val(c);
               ph_in             = cmnp_pkg::PH_DST_R;
            end else begin
               held_in.dest_file  = held_ff.first_file;
               held_in.dest_rank  = held_ff.first_rank;
               held_in.first_file = cmnp_pkg::SQ_NONE;
               held_in.first_rank = cmnp_pkg::SQ_NONE;
               r0    = cmnp_pkg::mk_move(held_in, cmnp_pkg::PC_PAWN);
               st    = start_byte(c, held_in);
               r1    = st.res;
               ph_in = st.phase;
               held_in = st.held;
               n_res = st.emit ? 2'd2 : 2'd1;
            end
         end
         cmnp_pkg::PH_PC_R: begin
            if (c == cmnp_pkg::CH_X) begin
               held_in.capture = 1'b1;
               ph_in           = cmnp_pkg::PH_DST_F;
            end else if (cmnp_pkg::is_file(c)) begin
               held_in.dest_file = cmnp_pkg::file_val(c);
               ph_in             = cmnp_pkg::PH_DST_R;
            end else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_DST_F: begin
            if (cmnp_pkg::is_file(c)) begin
               held_in.dest_file = cmnp_pkg::file_val(c);
               ph_in             = cmnp_pkg::PH_DST_R;
            end else begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end
         end
         cmnp_pkg::PH_DST_R: begin
            if (!cmnp_pkg::is_rank(c)) begin
               ph_in = cmnp_pkg::PH_START;
               n_res = 2'd1;
            end else begin
               held_in.dest_rank = cmnp_pkg::rank_val(c);
               if (held_ff.piece == cmnp_pkg::PC_PAWN) ph_in = cmnp_pkg::PH_PROMO;
               else begin
                  r0    = cmnp_pkg::mk_move(held_in, cmnp_pkg::PC_PAWN);
                  ph_in = cmnp_pkg::PH_START;
                  n_res = 2'd1;
               end
            end
         end
         default: begin
            r0      = st.res;
            ph_in   = st.phase;
            held_in = st.held;
            n_res   = st.emit ? 2'd1 : 2'd0;
         end
      endcase
      r0.last = (n_res == 2'd1);
      r1.last = 1'b1;
   end

   // Result queue
   assign push_n    = acc ? n_res : 2'd0;
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign wr_next   = wr_ptr_ff + cmnp_pkg::Q_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + cmnp_pkg::Q_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + cmnp_pkg::Q_PTR_W'(pop);
   assign count_in  = count_ff + cmnp_pkg::Q_CNT_W'(push_n) - cmnp_pkg::Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= cmnp_pkg::PH_START;
         held_ff   <= cmnp_pkg::HOLD_CLEAR;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (acc) begin
            ph_ff   <= ph_in;
            held_ff <= held_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < cmnp_pkg::Q_DEPTH; i++) begin
         if (push_n != 2'd0 && wr_ptr_ff == cmnp_pkg::Q_PTR_W'(i)) mem_ff[i] <= r0;
         else if (push_n == 2'd2 && wr_next == cmnp_pkg::Q_PTR_W'(i)) mem_ff[i] <= r1;
      end
   end

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.piece        = head.piece;
   assign rsp_chan.origin_file  = head.origin_file;
   assign rsp_chan.origin_rank  = head.origin_rank;
   assign rsp_chan.target_file  = head.target_file;
   assign rsp_chan.target_rank  = head.target_rank;
   assign rsp_chan.captures     = head.captures;
   assign rsp_chan.castle_short = head.castle_short;
   assign rsp_chan.castle_long  = head.castle_long;
   assign rsp_chan.promoted_to  = head.promoted_to;
   assign rsp_chan.bad_byte     = head.bad_byte;
   assign rsp_chan.last         = head.last;

endmodule

// ===== sim/move_check_pkg.sv =====
package move_check_pkg;
   import cmnp_pkg::*;

   class move_scoreboard;
      res_type           parse_results[$];
      int                faults;
      phase_type         phase;
      logic [2:0]        piece;
      logic signed [3:0] src_file;
      logic signed [3:0] src_rank;
      logic signed [3:0] to_file;
      logic signed [3:0] to_rank;
      logic              took;

      function new();
         faults = 0;
         phase  = PH_START;
         clear_move();
      endfunction

      function void clear_move();
         piece     = PC_PAWN;
         src_file  = SQ_NONE;
         src_rank  = SQ_NONE;
         to_file   = SQ_NONE;
         to_rank   = SQ_NONE;
         took      = 1'b0;
      endfunction

      function int file_num(logic [7:0] c);
         if (c >= CH_A && c <= CH_H) return int'(c - CH_A);
         return -1;
      endfunction

      function int rank_num(logic [7:0] c);
         if (c >= CH_1 && c <= CH_8) return int'(c - CH_1);
         return -1;
      endfunction

      function logic [2:0] letter_code(logic [7:0] c);
         case (c)
            CH_N:    return PC_KNIGHT;
            CH_B:    return PC_BISHOP;
            CH_R:    return PC_ROOK;
            CH_Q:    return PC_QUEEN;
            CH_K:    return PC_KING;
            default: return PC_PAWN;
         endcase
      endfunction

      function void push(logic [1:0] kind, logic [2:0] pc, logic signed [3:0] of,
                         logic signed [3:0] orank, logic signed [3:0] tf,
                         logic signed [3:0] tr, logic cap, logic cs, logic cl,
                         logic [2:0] promo, logic [7:0] bad);
         res_type r;
         r.kind         = kind;
         r.piece        = pc;
         r.origin_file  = of;
         r.origin_rank  = orank;
         r.target_file  = tf;
         r.target_rank  = tr;
         r.captures     = cap;
         r.castle_short = cs;
         r.castle_long  = cl;
         r.promoted_to  = promo;
         r.bad_byte     = bad;
         r.last         = 1'b0;
         parse_results.push_back(r);
      endfunction

      function void push_error(logic [7:0] c);
         push(KIND_ERR, PC_PAWN, SQ_NONE, SQ_NONE, SQ_NONE, SQ_NONE,
              1'b0, 1'b0, 1'b0, PC_PAWN, c);
         phase = PH_START;
      endfunction

      function void push_move(logic [2:0] promo);
         push(KIND_MOVE, piece, src_file, src_rank, to_file, to_rank,
              took, 1'b0, 1'b0, promo, 8'd0);
         phase = PH_START;
      endfunction

      function void push_castle(logic is_long);
         push(KIND_MOVE, PC_KING, SQ_NONE, SQ_NONE, SQ_NONE, SQ_NONE,
              1'b0, !is_long, is_long, PC_PAWN, 8'd0);
      endfunction

      function void start_token(logic [7:0] c);
         phase = PH_START;
         if (c == CH_SPACE) return;
         if (c == CH_LF || c == CH_CR) begin
            push(KIND_EOL, PC_PAWN, SQ_NONE, SQ_NONE, SQ_NONE, SQ_NONE,
                 1'b0, 1'b0, 1'b0, PC_PAWN, 8'd0);
            return;
         end
         clear_move();
         if (c == CH_O) begin
            piece = PC_KING;
            phase = PH_C1;
         end else if (file_num(c) >= 0) begin
            src_file = 4'(file_num(c));
            phase    = PH_PAWN_F;
         end else if (letter_code(c) != PC_PAWN) begin
            piece = letter_code(c);
            phase = PH_PC1;
         end else begin
            push_error(c);
         end
      endfunction

      function void take_dest_file(logic [7:0] c);
         if (file_num(c) < 0) begin
            push_error(c);
         end else begin
            to_file = 4'(file_num(c));
            phase   = PH_DST_R;
         end
      endfunction

      function void take_capture();
         took  = 1'b1;
         phase = PH_DST_F;
      endfunction

      function void note_char(logic [7:0] c);
         int prior_count;
         prior_count = parse_results.size();
         case (phase)
            PH_C1: begin
               if (c == CH_DASH) phase = PH_C2;
               else push_error(c);
            end
            PH_C2: begin
               if (c == CH_O) phase = PH_C3;
               else push_error(c);
            end
            PH_C3: begin
               if (c == CH_DASH) begin
                  phase = PH_C4;
               end else begin
                  push_castle(1'b0);
                  start_token(c);
               end
            end
            PH_C4: begin
               if (c == CH_O) begin
                  push_castle(1'b1);
                  phase = PH_START;
               end else begin
                  push_error(c);
               end
            end
            PH_PAWN_F: begin
               if (c == CH_X) begin
                  take_capture();
               end else if (rank_num(c) >= 0) begin
                  to_file  = src_file;
                  src_file = SQ_NONE;
                  to_rank  = 4'(rank_num(c));
                  phase    = PH_PROMO;
               end else begin
                  push_error(c);
               end
            end
            PH_PROMO: begin
               if (c == CH_EQ) begin
                  phase = PH_PROMO_EQ;
               end else begin
                  push_move(PC_PAWN);
                  start_token(c);
               end
            end
            PH_PROMO_EQ: begin
               if (letter_code(c) != PC_PAWN && letter_code(c) != PC_KING)
                  push_move(letter_code(c));
               else
                  push_error(c);
            end
            PH_PC1: begin
               if (file_num(c) >= 0) begin
                  src_file = 4'(file_num(c));
                  phase    = PH_PC_F;
               end else if (rank_num(c) >= 0) begin
                  src_rank = 4'(rank_num(c));
                  phase    = PH_PC_R;
               end else if (c == CH_X) begin
                  take_capture();
               end else begin
                  push_error(c);
               end
            end
            PH_PC_F: begin
               if (rank_num(c) >= 0) begin
                  src_rank = 4'(rank_num(c));
                  phase    = PH_PC_FR;
               end else if (c == CH_X) begin
                  take_capture();
               end else begin
                  take_dest_file(c);
               end
            end
            PH_PC_FR: begin
               if (c == CH_X) begin
                  take_capture();
               end else if (file_num(c) >= 0) begin
                  take_dest_file(c);
               end else begin
                  // the two bytes were the destination, not a disambiguation
                  to_file  = src_file;
                  to_rank  = src_rank;
                  src_file = SQ_NONE;
                  src_rank = SQ_NONE;
                  push_move(PC_PAWN);
                  start_token(c);
               end
            end
            PH_PC_R: begin
               if (c == CH_X) take_capture();
               else take_dest_file(c);
            end
            PH_DST_F: take_dest_file(c);
            PH_DST_R: begin
               if (rank_num(c) < 0) begin
                  push_error(c);
               end else begin
                  to_rank = 4'(rank_num(c));
                  if (piece == PC_PAWN) phase = PH_PROMO;
                  else push_move(PC_PAWN);
               end
            end
            default: start_token(c);
         endcase
         if (parse_results.size() > prior_count) parse_results[$].last = 1'b1;
      endfunction

      task report_mismatch(string msg);
         faults++;
         if (faults <= 40) $display("%0t ns: ERROR %s", $time, msg);
      endtask

      task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
         if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_result(res_type got);
         res_type want;
         if (parse_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d with no request pending", got.kind));
            return;
         end
         want = parse_results.pop_front();
         check_field("kind", got.kind, want.kind);
         check_field("piece", got.piece, want.piece);
         check_field("origin_file", got.origin_file, want.origin_file);
         check_field("origin_rank", got.origin_rank, want.origin_rank);
         check_field("target_file", got.target_file, want.target_file);
         check_field("target_rank", got.target_rank, want.target_rank);
         check_field("captures", got.captures, want.captures);
         check_field("castle_short", got.castle_short, want.castle_short);
         check_field("castle_long", got.castle_long, want.castle_long);
         check_field("promoted_to", got.promoted_to, want.promoted_to);
         check_field("bad_byte", got.bad_byte, want.bad_byte);
         check_field("last", got.last, want.last);
      endtask
   endclass

endpackage

// ===== sim/chess_move_notation_parser_test.sv =====
module chess_move_notation_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cmnp_pkg::*;
   import move_check_pkg::*;

   localparam int REQUEST_TARGET = 1150;
   localparam logic [7:0] PIECE_LETTERS [5] = '{CH_N, CH_B, CH_R, CH_Q, CH_K};
   localparam logic [7:0] PROMO_LETTERS [4] = '{CH_Q, CH_R, CH_B, CH_N};

   logic clock = 1'b0;
   logic reset = 1'b1;

   cmnp_req_if req_chan ();
   cmnp_rsp_if rsp_chan ();

   chess_move_notation_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   move_scoreboard sb = new();
   logic [7:0]     move_text[$];
   int             requests_sent = 0;
   int             results_taken = 0;
   int             send_calm = 0;
   int             recv_calm = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] file_char();
      return 8'(CH_A + $urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] rank_char();
      return 8'(CH_1 + $urandom_range(0, 7));
   endfunction

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = pick_wait(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_char(c);
      requests_sent++;
   endtask

   task automatic add_move();
      int shape;
      int dis;
      shape = $urandom_range(0, 5);
      if (shape == 0) begin
         move_text.push_back(CH_O);
         move_text.push_back(CH_DASH);
         move_text.push_back(CH_O);
         if ($urandom_range(0, 1) == 1) begin
            move_text.push_back(CH_DASH);
            move_text.push_back(CH_O);
         end
      end else if (shape <= 2) begin
         move_text.push_back(file_char());
         if ($urandom_range(0, 1) == 1) begin
            move_text.push_back(CH_X);
            move_text.push_back(file_char());
         end
         move_text.push_back(rank_char());
         if ($urandom_range(0, 3) == 0) begin
            move_text.push_back(CH_EQ);
            move_text.push_back(PROMO_LETTERS[$urandom_range(0, 3)]);
         end
      end else begin
         move_text.push_back(PIECE_LETTERS[$urandom_range(0, 4)]);
         dis = $urandom_range(0, 3);
         if (dis[0]) move_text.push_back(file_char());
         if (dis[1]) move_text.push_back(rank_char());
         if ($urandom_range(0, 2) == 0) move_text.push_back(CH_X);
         move_text.push_back(file_char());
         move_text.push_back(rank_char());
      end
   endtask

   task automatic add_token();
      int pick;
      int cut;
      int sep;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         repeat ($urandom_range(1, 3)) move_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_move();
         // break a few moves: overwrite one byte or cut the tail
         if (pick < 4) begin
            cut = $urandom_range(0, move_text.size() - 1);
            if (pick == 2) move_text[cut] = 8'($urandom_range(0, 255));
            else while (move_text.size() > cut) void'(move_text.pop_back());
         end
      end
      sep = $urandom_range(0, 9);
      if (sep <= 5) begin
         move_text.push_back(CH_SPACE);
      end else if (sep == 6) begin
         move_text.push_back(CH_LF);
      end else if (sep == 7) begin
         move_text.push_back(CH_CR);
      end else if (sep == 9) begin
         move_text.push_back(CH_SPACE);
         move_text.push_back(CH_SPACE);
      end
   endtask

   initial begin
      string opening;
      int    spin;
      req_chan.valid     = 1'b0;
      req_chan.char_byte = 8'd0;
      opening = "O-O\nO-O-O exd8=QNd1b5e4";
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_char(8'h00);
      for (int i = 0; i < opening.len(); i++) send_char(opening[i]);
      send_char(8'hff);

      while (requests_sent < REQUEST_TARGET) begin
         move_text.delete();
         add_token();
         foreach (move_text[i]) send_char(move_text[i]);
      end
      req_chan.valid <= 1'b0;

      spin = 0;
      while (sb.parse_results.size() != 0 && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (10) @(posedge clock);
      if (sb.parse_results.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.parse_results.size()));

      if (sb.faults == 0) begin
         $display("chess_move_notation_parser test passed");
      end else begin
         $display("chess_move_notation_parser test failed");
      end
      $finish;
   end

   initial begin
      int      gap;
      res_type got;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         // hold off long enough to fill the result queue and stall requests
         if (results_taken == 200 || results_taken == 800) gap = 400;
         else gap = pick_wait(recv_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.kind         = rsp_chan.kind;
         got.piece        = rsp_chan.piece;
         got.origin_file  = rsp_chan.origin_file;
         got.origin_rank  = rsp_chan.origin_rank;
         got.target_file  = rsp_chan.target_file;
         got.target_rank  = rsp_chan.target_rank;
         got.captures     = rsp_chan.captures;
         got.castle_short = rsp_chan.castle_short;
         got.castle_long  = rsp_chan.castle_long;
         got.promoted_to  = rsp_chan.promoted_to;
         got.bad_byte     = rsp_chan.bad_byte;
         got.last         = rsp_chan.last;
         sb.check_result(got);
         results_taken++;
      end
   end

   initial begin
      #5_000_000;
      $display("chess_move_notation_parser test failed");
      $finish;
   end

endmodule
